// ===== sv/cbgw_pkg.sv =====
// Shared types, constants and helpers for the 2-D cubic B-spline grid weight block
`timescale 1ns / 1ps

package cbgw_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ORIGIN_X  = 2'd0,
    CFG_ORIGIN_Y  = 2'd1,
    CFG_INV_WIDTH = 2'd2
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic signed [31:0] ORIGIN_RST    = 32'sd0;
  localparam logic [30:0]        INV_WIDTH_RST = 31'd65536;

  // Kernel constants, Q2.30
  localparam logic [30:0] TWO_THIRDS_Q30 = 31'd715827883;
  localparam logic [30:0] ONE_Q30        = 31'h4000_0000;

  // Reciprocal of three: floor(x / 3) = (x * DIV3_RECIP) >> 33 for any 32-bit x
  localparam logic [31:0] DIV3_RECIP = 32'hAAAA_AAAB;

  // Cell position limit, +-2^18 cells (raw 2^50 in Q32.32)
  localparam logic signed [63:0] P_LIMIT = 64'sh0004_0000_0000_0000;

  // Per-axis values after the offset stage
  typedef struct packed {
    logic [24:0] u;        // a (when below one cell) or 2 - a, Q.24
    logic        inner;    // offset magnitude below one cell
    logic        far;      // offset magnitude two cells or more
    logic        neg;      // offset >= 0, derivative is negative
    logic [9:0]  start;    // stencil start
    logic        clamped;  // stencil start was clamped
  } axis_mid_t;

  // Per-axis kernel value and derivative magnitude
  typedef struct packed {
    logic [30:0] n;        // N, Q2.30
    logic [30:0] dmag;     // |N'|, Q2.30
    logic        neg;
    logic [9:0]  start;
    logic        clamped;
  } axis_kern_t;

  // One finished result
  typedef struct packed {
    logic [30:0] weight;
    logic [31:0] grad_x;
    logic [31:0] grad_y;
    logic [9:0]  start_x;
    logic [9:0]  start_y;
    logic        clamped;
  } result_t;

  // Give a gradient magnitude its sign and saturate to 32 bits
  function automatic logic [31:0] grad_sat(input logic [31:0] mag, input logic neg);
    logic [31:0] lim;
    begin
      if (neg) begin
        lim = (mag > 32'h8000_0000) ? 32'h8000_0000 : mag;
        grad_sat = 32'd0 - lim;
      end else begin
        grad_sat = (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
      end
    end
  endfunction

endpackage

// ===== sv/cbgw_axis_front.sv =====
// Per-axis front end: cell position multiply, node offset and stencil start
`timescale 1ns / 1ps

module cbgw_axis_front
  import cbgw_pkg::*;
#(
  parameter int GRID_DIM = 1024
) (
  input  logic               clk,
  input  logic signed [31:0] pos,
  input  logic signed [31:0] origin,
  input  logic [30:0]        inv_width,
  input  logic [9:0]         node,
  output axis_mid_t          mid_o
);

  localparam logic signed [32:0] START_MAX = 33'(GRID_DIM - 4);

  logic signed [63:0] diff_w;
  logic signed [63:0] inv_w;
  logic signed [63:0] p_r;
  logic [9:0]         node_r;

  logic signed [63:0] pc64;
  logic signed [51:0] off;
  logic [51:0]        mag;
  logic [24:0]        a25;
  logic signed [32:0] s;
  axis_mid_t          mid_nxt;
  axis_mid_t          mid_r;

  // Stage 1: cell position (particle - origin) * inv_width, exact Q32.32
  assign diff_w = 64'(pos) - 64'(origin);
  assign inv_w  = $signed({33'd0, inv_width});

  always_ff @(posedge clk) begin
    p_r    <= diff_w * inv_w;
    node_r <= node;
  end

  // Stage 2: limit, subtract node, take magnitude, pick kernel operand
  always_comb begin
    if (p_r > P_LIMIT) begin
      pc64 = P_LIMIT;
    end else if (p_r < -P_LIMIT) begin
      pc64 = -P_LIMIT;
    end else begin
      pc64 = p_r;
    end
    off = $signed(pc64[51:0]) - $signed({10'd0, node_r, 32'd0});
    mag = off[51] ? 52'(-off) : 52'(off);
    a25 = mag[32:8];

    mid_nxt.far   = |mag[51:33];
    mid_nxt.inner = ~a25[24];
    mid_nxt.neg   = ~off[51];
    // 2 - a wraps correctly in 25 bits since a is nonzero here
    mid_nxt.u     = a25[24] ? (25'd0 - a25) : {1'b0, a25[23:0]};

    // Stencil start floor(p) - 1, clamped into the grid
    s = 33'($signed(p_r[63:32])) - 33'sd1;
    if (s < 0) begin
      mid_nxt.start   = 10'd0;
      mid_nxt.clamped = 1'b1;
    end else if (s > START_MAX) begin
      mid_nxt.start   = START_MAX[9:0];
      mid_nxt.clamped = 1'b1;
    end else begin
      mid_nxt.start   = s[9:0];
      mid_nxt.clamped = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    mid_r <= mid_nxt;
  end

  assign mid_o = mid_r;

endmodule

// ===== sv/cbgw_kernel.sv =====
// Per-axis cubic B-spline kernel: square, cube, value and derivative magnitude
`timescale 1ns / 1ps

module cbgw_kernel
  import cbgw_pkg::*;
(
  input  logic       clk,
  input  axis_mid_t  mid_i,
  output axis_kern_t kern_o
);

  logic [49:0] sq_prod;
  logic [49:0] cu_prod;
  logic [61:0] div_prod;

  axis_mid_t   s3_mid_r;
  logic [24:0] s3_u2_r;

  axis_mid_t   s4_mid_r;
  logic [24:0] s4_u2_r;
  logic [24:0] s4_u3_r;
  logic [30:0] s4_dmag_r;

  logic signed [32:0] d_inner;
  logic [30:0]        dmag_nxt;
  logic signed [33:0] n_inner;
  logic [29:0]        div_x;
  logic [30:0]        n_nxt;
  axis_kern_t         kern_nxt;
  axis_kern_t         kern_r;

  // Stage 3: square of the operand, Q.24
  assign sq_prod = mid_i.u * mid_i.u;

  always_ff @(posedge clk) begin
    s3_mid_r <= mid_i;
    s3_u2_r  <= sq_prod[48:24];
  end

  // Stage 4: cube, and derivative magnitude on each branch
  assign cu_prod = s3_u2_r * s3_mid_r.u;

  always_comb begin
    d_inner = $signed({1'b0, s3_mid_r.u, 7'd0})
            - $signed({2'd0, s3_u2_r, 6'd0}) - $signed({3'd0, s3_u2_r, 5'd0});
    if (s3_mid_r.inner) begin
      dmag_nxt = d_inner[32] ? 31'd0 : d_inner[30:0];
    end else begin
      dmag_nxt = {1'b0, s3_u2_r, 5'd0};
    end
  end

  always_ff @(posedge clk) begin
    s4_mid_r  <= s3_mid_r;
    s4_u2_r   <= s3_u2_r;
    s4_u3_r   <= cu_prod[48:24];
    s4_dmag_r <= dmag_nxt;
  end

  // Stage 5: kernel value; outer branch divides by six through a reciprocal
  assign div_x    = {s4_u3_r, 5'd0};
  assign div_prod = div_x * DIV3_RECIP;

  always_comb begin
    n_inner = $signed({4'd0, s4_u3_r, 5'd0}) - $signed({3'd0, s4_u2_r, 6'd0})
            + $signed({3'd0, TWO_THIRDS_Q30});
    if (s4_mid_r.inner) begin
      if (n_inner < 0) begin
        n_nxt = 31'd0;
      end else if (n_inner > $signed({3'd0, ONE_Q30})) begin
        n_nxt = ONE_Q30;
      end else begin
        n_nxt = n_inner[30:0];
      end
    end else begin
      n_nxt = {2'd0, div_prod[61:33]};
    end

    // Zero both beyond two cells
    kern_nxt.n       = s4_mid_r.far ? 31'd0 : n_nxt;
    kern_nxt.dmag    = s4_mid_r.far ? 31'd0 : s4_dmag_r;
    kern_nxt.neg     = s4_mid_r.neg;
    kern_nxt.start   = s4_mid_r.start;
    kern_nxt.clamped = s4_mid_r.clamped;
  end

  always_ff @(posedge clk) begin
    kern_r <= kern_nxt;
  end

  assign kern_o = kern_r;

endmodule

// ===== sv/cbgw_grad.sv =====
// Weight product and scaled, saturated gradient from both axis kernels
`timescale 1ns / 1ps

module cbgw_grad
  import cbgw_pkg::*;
(
  input  logic        clk,
  input  axis_kern_t  kx,
  input  axis_kern_t  ky,
  input  logic [30:0] inv_width,
  output result_t     res_o
);

  logic [61:0] w_prod;
  logic [61:0] gx_prod;
  logic [61:0] gy_prod;

  logic [30:0] w_r;
  logic [30:0] gx1_r;
  logic [30:0] gy1_r;
  logic        negx_r;
  logic        negy_r;
  logic [9:0]  start_x_r;
  logic [9:0]  start_y_r;
  logic        clamped_r;

  logic [61:0] gx_scaled;
  logic [61:0] gy_scaled;
  result_t     res_nxt;
  result_t     res_r;

  // Stage 6: weight and unscaled gradient products, truncated to Q.30
  assign w_prod  = kx.n * ky.n;
  assign gx_prod = kx.dmag * ky.n;
  assign gy_prod = ky.dmag * kx.n;

  always_ff @(posedge clk) begin
    w_r       <= w_prod[60:30];
    gx1_r     <= gx_prod[60:30];
    gy1_r     <= gy_prod[60:30];
    negx_r    <= kx.neg;
    negy_r    <= ky.neg;
    start_x_r <= kx.start;
    start_y_r <= ky.start;
    clamped_r <= kx.clamped | ky.clamped;
  end

  // Stage 7: scale by the inverse cell width, sign and saturate
  assign gx_scaled = gx1_r * inv_width;
  assign gy_scaled = gy1_r * inv_width;

  always_comb begin
    res_nxt.weight  = w_r;
    res_nxt.grad_x  = grad_sat(gx_scaled[61:30], negx_r);
    res_nxt.grad_y  = grad_sat(gy_scaled[61:30], negy_r);
    res_nxt.start_x = start_x_r;
    res_nxt.start_y = start_y_r;
    res_nxt.clamped = clamped_r;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_o = res_r;

endmodule

// ===== sv/cubic_bspline_grid_weight_2d.sv =====
// Top level of the 2-D cubic B-spline grid weight and gradient pipeline
//
//   channel  handshake              payload
//   -------  ---------------------  ---------------------------------------------
//   input    start, busy            in_particle_x/y, in_node_x/y
//   result   out_strobe (1 cycle)   out_node_weight, out_grad_x/y,
//                                   out_stencil_start_x/y, out_stencil_clamped
//   config   cfg_we                 cfg_index, cfg_wdata
//
// One item enters per clock outside reset; each result comes out of the seven register
// stages (position multiply, offset, square, cube, kernel value, weight product,
// gradient scale).
// busy is high only while rst_n is low; reset clears the valid bits in flight.
// Results are never held: out_strobe marks each for exactly one cycle.
`timescale 1ns / 1ps

module cubic_bspline_grid_weight_2d
  import cbgw_pkg::*;
#(
  parameter int GRID_DIM = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  // input item
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_particle_x,
  input  logic signed [31:0] in_particle_y,
  input  logic [9:0]         in_node_x,
  input  logic [9:0]         in_node_y,
  // result item
  output logic               out_strobe,
  output logic [30:0]        out_node_weight,
  output logic signed [31:0] out_grad_x,
  output logic signed [31:0] out_grad_y,
  output logic [9:0]         out_stencil_start_x,
  output logic [9:0]         out_stencil_start_y,
  output logic               out_stencil_clamped,
  // configuration
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int LATENCY = 7;

  logic signed [31:0] origin_x_r, origin_x_nxt;
  logic signed [31:0] origin_y_r, origin_y_nxt;
  logic [30:0]        inv_width_r, inv_width_nxt;
  logic [LATENCY-1:0] vld_r;
  logic               in_acc;

  axis_mid_t  mid_x, mid_y;
  axis_kern_t kern_x, kern_y;
  result_t    res;

  // Configuration write decode
  always_comb begin
    origin_x_nxt  = origin_x_r;
    origin_y_nxt  = origin_y_r;
    inv_width_nxt = inv_width_r;
    if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        CFG_ORIGIN_X:  origin_x_nxt  = $signed(cfg_wdata);
        CFG_ORIGIN_Y:  origin_y_nxt  = $signed(cfg_wdata);
        CFG_INV_WIDTH: inv_width_nxt = cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= ORIGIN_RST;
      origin_y_r  <= ORIGIN_RST;
      inv_width_r <= INV_WIDTH_RST;
    end else begin
      origin_x_r  <= origin_x_nxt;
      origin_y_r  <= origin_y_nxt;
      inv_width_r <= inv_width_nxt;
    end
  end

  // Accept an item every cycle outside reset; advance the valid bits with the data
  assign busy   = ~rst_n;
  assign in_acc = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LATENCY-2:0], in_acc};
    end
  end

  cbgw_axis_front #(.GRID_DIM(GRID_DIM)) u_front_x (
    .clk       (clk),
    .pos       (in_particle_x),
    .origin    (origin_x_r),
    .inv_width (inv_width_r),
    .node      (in_node_x),
    .mid_o     (mid_x)
  );

  cbgw_axis_front #(.GRID_DIM(GRID_DIM)) u_front_y (
    .clk       (clk),
    .pos       (in_particle_y),
    .origin    (origin_y_r),
    .inv_width (inv_width_r),
    .node      (in_node_y),
    .mid_o     (mid_y)
  );

  cbgw_kernel u_kernel_x (
    .clk    (clk),
    .mid_i  (mid_x),
    .kern_o (kern_x)
  );

  cbgw_kernel u_kernel_y (
    .clk    (clk),
    .mid_i  (mid_y),
    .kern_o (kern_y)
  );

  cbgw_grad u_grad (
    .clk       (clk),
    .kx        (kern_x),
    .ky        (kern_y),
    .inv_width (inv_width_r),
    .res_o     (res)
  );

  // Drive the result ports
  assign out_strobe          = vld_r[LATENCY-1];
  assign out_node_weight     = res.weight;
  assign out_grad_x          = $signed(res.grad_x);
  assign out_grad_y          = $signed(res.grad_y);
  assign out_stencil_start_x = res.start_x;
  assign out_stencil_start_y = res.start_y;
  assign out_stencil_clamped = res.clamped;

  // Every accepted item produces a result marked by out_strobe
  a_latency_fwd : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##LATENCY out_strobe)
    else $error("accepted item did not produce a result");

  a_latency_bwd : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(in_acc, LATENCY))
    else $error("result without a matching item");

  // The weight is a product of two kernel values of at most one
  a_weight_max : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_node_weight <= ONE_Q30)
    else $error("weight above one");

  // An unclamped stencil start lies inside the grid
  a_start_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_stencil_clamped && (GRID_DIM <= 1024) |->
      out_stencil_start_x <= 10'(GRID_DIM - 4) &&
      out_stencil_start_y <= 10'(GRID_DIM - 4))
    else $error("unclamped stencil start outside the grid");

endmodule

// ===== test/tb.sv =====
// Self-checking bench for the 2-D cubic B-spline grid weight and gradient pipeline
`timescale 1ns / 1ps

module tb;
  import cbgw_pkg::*;

  localparam int     GRID_DIM      = 1024;
  localparam int     PIPE_LATENCY  = 7;
  localparam int     RANDOM_ITEMS  = 700;
  localparam int     RANDOM_PHASES = 4;
  localparam longint Q24_ONE       = 64'sd16777216;
  localparam longint Q24_TWO       = 64'sd33554432;
  localparam longint Q30_ONE       = 64'sd1073741824;
  localparam longint TWO_THIRDS    = 64'sd715827883;
  localparam longint GRAD_POS_MAX  = 64'sd2147483647;
  localparam longint GRAD_NEG_MAX  = 64'sd2147483648;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] in_particle_x = '0;
  logic signed [31:0] in_particle_y = '0;
  logic [9:0]         in_node_x = '0;
  logic [9:0]         in_node_y = '0;
  logic               out_strobe;
  logic [30:0]        out_node_weight;
  logic signed [31:0] out_grad_x;
  logic signed [31:0] out_grad_y;
  logic [9:0]         out_stencil_start_x;
  logic [9:0]         out_stencil_start_y;
  logic               out_stencil_clamped;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_wdata = '0;

  // Shadow copy of the configuration registers
  longint origin_x_q16  = 0;
  longint origin_y_q16  = 0;
  longint inv_width_q16 = 65536;

  result_t weights_in_flight[$];
  int      mismatch_cnt = 0;
  int      burst_left   = 0;
  bit      no_idle      = 1'b0;

  cubic_bspline_grid_weight_2d #(
    .GRID_DIM(GRID_DIM)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_particle_x      (in_particle_x),
    .in_particle_y      (in_particle_y),
    .in_node_x          (in_node_x),
    .in_node_y          (in_node_y),
    .out_strobe         (out_strobe),
    .out_node_weight    (out_node_weight),
    .out_grad_x         (out_grad_x),
    .out_grad_y         (out_grad_y),
    .out_stencil_start_x(out_stencil_start_x),
    .out_stencil_start_y(out_stencil_start_y),
    .out_stencil_clamped(out_stencil_clamped),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Kernel value and derivative magnitude (Q2.30) plus stencil start for one axis
  function automatic void axis_kernel(input logic signed [31:0] pos, input longint origin,
                                      input logic [9:0] node, output longint n30,
                                      output longint dmag30, output bit neg,
                                      output logic [9:0] start_idx, output bit clamp);
    longint d, p, pc, off, mag, a, a2, a3, b, b2, b3, nv, dv, s;
    d  = longint'(pos) - origin;
    p  = d * inv_width_q16;
    pc = p;
    // Limit huge cell positions; the kernel is zero out there anyway
    if (pc > P_LIMIT) pc = P_LIMIT;
    if (pc < -P_LIMIT) pc = -P_LIMIT;
    off = pc - (longint'(node) << 32);
    mag = (off >= 0) ? off : -off;
    a   = mag >> 8;
    if (a < Q24_ONE) begin
      a2 = (a * a) >> 24;
      a3 = (a2 * a) >> 24;
      nv = (a3 << 5) - (a2 << 6) + TWO_THIRDS;
      dv = (a << 7) - a2 * 96;
      if (nv < 0) nv = 0;
      if (nv > Q30_ONE) nv = Q30_ONE;
      if (dv < 0) dv = 0;
    end else if (a < Q24_TWO) begin
      b  = Q24_TWO - a;
      b2 = (b * b) >> 24;
      b3 = (b2 * b) >> 24;
      nv = (b3 << 6) / 6;
      dv = b2 << 5;
    end else begin
      nv = 0;
      dv = 0;
    end
    n30    = nv;
    dmag30 = dv;
    neg    = (off >= 0);
    // Stencil starts one node below the floor of the unlimited cell position
    s     = (p >>> 32) - 1;
    clamp = 1'b0;
    if (s < 0) begin
      s     = 0;
      clamp = 1'b1;
    end else if (s > GRID_DIM - 4) begin
      s     = GRID_DIM - 4;
      clamp = 1'b1;
    end
    start_idx = s[9:0];
  endfunction

  // Scale a derivative product by the inverse width, round toward zero, saturate
  function automatic logic [31:0] signed_grad(input longint dmag, input longint other,
                                              input bit neg);
    longint g;
    g = (((dmag * other) >> 30) * inv_width_q16) >> 30;
    if (neg) begin
      if (g > GRAD_NEG_MAX) g = GRAD_NEG_MAX;
      g = -g;
    end else if (g > GRAD_POS_MAX) begin
      g = GRAD_POS_MAX;
    end
    return g[31:0];
  endfunction

  function automatic result_t compute_node_weight(input logic signed [31:0] px,
                                                  input logic signed [31:0] py,
                                                  input logic [9:0] nx,
                                                  input logic [9:0] ny);
    longint     kx, dx, ky, dy, w;
    bit         negx, negy, clx, cly;
    logic [9:0] sx, sy;
    result_t    r;
    axis_kernel(px, origin_x_q16, nx, kx, dx, negx, sx, clx);
    axis_kernel(py, origin_y_q16, ny, ky, dy, negy, sy, cly);
    w         = (kx * ky) >> 30;
    r.weight  = w[30:0];
    r.grad_x  = signed_grad(dx, ky, negx);
    r.grad_y  = signed_grad(dy, kx, negy);
    r.start_x = sx;
    r.start_y = sy;
    r.clamped = clx | cly;
    return r;
  endfunction

  // Idle cycles before the next item: mostly none, some short, a few long
  function automatic int next_gap();
    int r;
    if (no_idle) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Particle coordinate that lands within about two cells of the node
  function automatic logic [31:0] particle_near(input longint origin, input logic [9:0] node);
    longint cell_pos, d;
    int     k;
    if ($urandom_range(0, 7) == 0) begin
      k        = $urandom_range(0, 4);
      cell_pos = (longint'(node) + k - 2) <<< 32;
    end else begin
      cell_pos = (longint'(node) << 32) + longint'($signed($urandom)) * 5;
    end
    d = cell_pos / inv_width_q16;
    d = origin + d;
    return d[31:0];
  endfunction

  function automatic logic [9:0] pick_node();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? 10'($urandom_range(0, 3)) : 10'($urandom_range(1020, 1023));
    return 10'($urandom_range(0, 1023));
  endfunction

  // Offer one item, hold it until taken, then record its expected result
  task automatic send_item(input logic signed [31:0] px, input logic signed [31:0] py,
                           input logic [9:0] nx, input logic [9:0] ny);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start         <= 1'b1;
    in_particle_x <= px;
    in_particle_y <= py;
    in_node_x     <= nx;
    in_node_y     <= ny;
    @(posedge clk);
    while (busy) @(posedge clk);
    weights_in_flight.push_back(compute_node_weight(px, py, nx, ny));
  endtask

  // Drop start and wait until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (weights_in_flight.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_ORIGIN_X:  origin_x_q16 = longint'($signed(val));
      CFG_ORIGIN_Y:  origin_y_q16 = longint'($signed(val));
      CFG_INV_WIDTH: inv_width_q16 = longint'(val[30:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_grid(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] inv);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_INV_WIDTH, inv);
  endtask

  // Kernel branches at reset config: zero offset, inside one cell, boundaries, far
  task automatic test_kernel_points();
    send_item(32'sh0005_0000, 32'sh0005_8000, 10'd5, 10'd5);
    send_item(32'sh0004_4000, 32'sh0006_0000, 10'd5, 10'd5);
    send_item(32'sh0003_0000, 32'sh0006_FFFF, 10'd5, 10'd5);
    send_item(32'sh0007_0000, 32'sh0003_0001, 10'd5, 10'd5);
    send_item(32'sh0064_A000, 32'sh0063_5555, 10'd100, 10'd100);
    send_item(32'sh01FF_C000, 32'sh0200_4000, 10'd511, 10'd512);
    send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 10'd1023, 10'd0);
    send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 10'd0, 10'd1023);
    drain_results();
  endtask

  // Stencil start at and just past both grid ends
  task automatic test_stencil_edges();
    send_item(32'sh0001_8000, 32'sh0000_8000, 10'd0, 10'd1);
    send_item(32'sh03FD_8000, 32'sh03FE_0000, 10'd1022, 10'd1023);
    send_item(32'shFFFF_8000, 32'sh0000_0000, 10'd0, 10'd0);
    send_item(32'sh0002_0000, 32'sh03FD_FFFF, 10'd2, 10'd1021);
    send_item(32'sh0400_0000, 32'shFFFF_FFFF, 10'd1023, 10'd0);
    drain_results();
  endtask

  // Register extremes: limited cell positions, smallest and largest inverse width
  task automatic test_config_extremes();
    write_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 10'd0, 10'd0);
    send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 10'd1023, 10'd1023);
    send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 10'd0, 10'd0);
    send_item(32'sh8000_0001, 32'sh7FFF_FFFE, 10'd0, 10'd0);
    drain_results();
    write_grid(32'h0000_0000, 32'h0000_0000, 32'h0000_0001);
    send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 10'd0, 10'd0);
    send_item(32'sh1234_5678, 32'shFEDC_BA98, 10'd0, 10'd1023);
    drain_results();
    write_reg(CFG_INV_WIDTH, 32'h7FFF_FFFF);
    send_item(32'sh0000_0001, 32'shFFFF_FFFF, 10'd0, 10'd0);
    send_item(32'sh0000_0002, 32'sh0000_0003, 10'd0, 10'd1);
    drain_results();
  endtask

  // Random grids; most items near their node, the rest anywhere
  task automatic test_random_streams();
    logic signed [31:0] px, py;
    logic [9:0]         nx, ny;
    logic signed [31:0] ox, oy;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      ox = $signed($urandom) >>> 3;
      oy = $signed($urandom) >>> 3;
      if (ph == 0) write_grid(32'h0, 32'h0, 32'h0001_0000);
      else write_grid(ox, oy, $urandom_range(1 << 12, 1 << 22));
      no_idle = (ph == 1);
      for (int i = 0; i < RANDOM_ITEMS / RANDOM_PHASES; i++) begin
        nx = pick_node();
        ny = pick_node();
        px = ($urandom_range(0, 4) == 0) ? $signed($urandom) : particle_near(origin_x_q16, nx);
        py = ($urandom_range(0, 4) == 0) ? $signed($urandom) : particle_near(origin_y_q16, ny);
        send_item(px, py, nx, ny);
      end
      no_idle = 1'b0;
      drain_results();
    end
  endtask

  // Compare each result with the oldest outstanding expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_strobe) begin
      if (weights_in_flight.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected result: weight %h grad %h %h start %0d %0d clamp %b",
                   out_node_weight, out_grad_x, out_grad_y, out_stencil_start_x,
                   out_stencil_start_y, out_stencil_clamped);
        mismatch_cnt++;
      end else begin
        want = weights_in_flight.pop_front();
        if (want.weight !== out_node_weight || want.grad_x !== out_grad_x ||
            want.grad_y !== out_grad_y || want.start_x !== out_stencil_start_x ||
            want.start_y !== out_stencil_start_y || want.clamped !== out_stencil_clamped) begin
          if (mismatch_cnt < 10) begin
            $display("mismatch: exp weight %h grad %h %h start %0d %0d clamp %b",
                     want.weight, want.grad_x, want.grad_y, want.start_x, want.start_y,
                     want.clamped);
            $display("          got weight %h grad %h %h start %0d %0d clamp %b",
                     out_node_weight, out_grad_x, out_grad_y, out_stencil_start_x,
                     out_stencil_start_y, out_stencil_clamped);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_kernel_points();
    test_stencil_edges();
    test_config_extremes();
    test_random_streams();
    drain_results();
    if (mismatch_cnt == 0 && weights_in_flight.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cbgw_pkg.sv
sv/cbgw_axis_front.sv
sv/cbgw_kernel.sv
sv/cbgw_grad.sv
sv/cubic_bspline_grid_weight_2d.sv
test/tb.sv
